>>> hdl/edp_pkg.sv
package edp_pkg;

   localparam int CMD_W       = 3;
   localparam int PORT_W      = 10;
   localparam int IRQ_W       = 8;
   localparam int MAP_W       = IRQ_W + 1;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_RAISE  = 3'd0,
      CMD_MASK   = 3'd1,
      CMD_UNMASK = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_BIND   = 3'd4,
      CMD_UNBIND = 3'd5,
      CMD_NEXT   = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_MAP,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      PH_WORD,
      PH_BIT,
      PH_POST
   } phase_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic exec;
      logic scan_step;
      logic map_rd;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_next;
      logic scan_done;
   } dp_stat_type;

   typedef struct packed {
      logic              found;
      logic [PORT_W-1:0] out_port;
      logic [IRQ_W-1:0]  out_irq;
      logic              is_bound;
      logic              upcall;
   } result_type;

endpackage

>>> hdl/edp_ctrl.sv
module edp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   input  edp_pkg::dp_stat_type  stat,
   output logic                  req_ready,
   output edp_pkg::ctrl_cmd_type cmd
);
   import edp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.is_next ? ST_SCAN : ST_MAP;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_MAP: begin
            cmd.map_rd = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hdl/edp_datapath.sv
module edp_datapath #(
   parameter int WORD_BITS = 32,
   parameter int NUM_PORTS = 1024,
   parameter int NUM_IRQS  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  edp_pkg::ctrl_cmd_type         cmd,
   input  logic [edp_pkg::CMD_W-1:0]     req_command,
   input  logic [edp_pkg::PORT_W-1:0]    req_port,
   input  logic [edp_pkg::IRQ_W-1:0]     req_irq,
   output edp_pkg::dp_stat_type          stat,
   output edp_pkg::result_type           result
);
   import edp_pkg::*;

   localparam int NUM_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int LB_W      = $clog2(WORD_BITS);
   localparam int MA_W      = $clog2(NUM_PORTS);
   localparam int PW        = $clog2(WORD_BITS * WORD_BITS);
   localparam logic [LB_W-1:0] TOP = LB_W'(WORD_BITS - 1);

   function automatic logic [LB_W-1:0] lowest(input logic [WORD_BITS-1:0] x);
      logic [LB_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (x[i]) r = LB_W'(i);
      end
      return r;
   endfunction

   cmd_type               command_ff, command_in;
   logic [PORT_W-1:0]     port_ff, port_in;
   logic [IRQ_W-1:0]      irq_ff, irq_in;
   logic [WORD_BITS-1:0]  pend_ff [NUM_WORDS];
   logic [WORD_BITS-1:0]  mask_ff [NUM_WORDS];
   logic [WORD_BITS-1:0]  live_ff, live_in;
   logic [WORD_BITS-1:0]  work_ff, work_in;
   logic                  flag_ff, flag_in;
   logic [LB_W-1:0]       last_word_ff, last_word_in;
   logic [LB_W-1:0]       last_bit_ff, last_bit_in;
   logic [LB_W-1:0]       lw_ff, lw_in;
   logic [LB_W-1:0]       lb_ff, lb_in;
   phase_type             phase_ff, phase_in;
   logic                  found_ff, found_in;
   logic [PW-1:0]         hit_ff, hit_in;
   logic [MA_W-1:0]       clr_ff, clr_in;
   logic [MAP_W-1:0]      map_mem [NUM_PORTS];
   logic [MAP_W-1:0]      map_q_ff;
   logic                  map_ok_ff, map_ok_in;

   logic [31:0]           port_ext, pword, word_sel;
   logic                  in_range, word_ok, is_next;
   logic [LB_W-1:0]       pbit, psel, start, bsel;
   logic [WI_W-1:0]       widx;
   logic [WORD_BITS-1:0]  pend_w, mask_w, act, pmask, m1, m2, ones, one;
   logic                  arr_we;
   logic [WORD_BITS-1:0]  pend_wr, mask_wr;
   logic                  map_we;
   logic [MA_W-1:0]       map_wa, map_ra;
   logic [MAP_W-1:0]      map_wd;
   logic                  fire;
   logic                  scan_done;

   assign ones     = '1;
   assign one      = {{(WORD_BITS-1){1'b0}}, 1'b1};
   assign is_next  = (command_ff == CMD_NEXT);
   assign port_ext = 32'(port_ff);
   assign in_range = port_ext < NUM_PORTS;
   assign pword    = port_ext / WORD_BITS;
   assign pbit     = LB_W'(port_ext % WORD_BITS);
   assign psel     = LB_W'(pword);
   assign word_sel = cmd.scan_step ? 32'(lw_ff) : pword;
   assign word_ok  = word_sel < NUM_WORDS;
   assign widx     = WI_W'(word_sel);
   assign pend_w   = word_ok ? pend_ff[widx] : '0;
   assign mask_w   = word_ok ? mask_ff[widx] : '1;
   assign act      = pend_w & ~mask_w;
   assign pmask    = one << pbit;

   always_comb begin
      command_in   = command_ff;
      port_in      = port_ff;
      irq_in       = irq_ff;
      live_in      = live_ff;
      work_in      = work_ff;
      flag_in      = flag_ff;
      last_word_in = last_word_ff;
      last_bit_in  = last_bit_ff;
      lw_in        = lw_ff;
      lb_in        = lb_ff;
      phase_in     = phase_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      clr_in       = clr_ff;
      map_ok_in    = map_ok_ff;
      arr_we       = 1'b0;
      pend_wr      = pend_w;
      mask_wr      = mask_w;
      map_we       = 1'b0;
      map_wa       = MA_W'(port_ext);
      map_wd       = '0;
      map_ra       = MA_W'(port_ext);
      fire         = 1'b0;
      start        = '0;
      bsel         = '0;
      m1           = '0;
      m2           = '0;
      scan_done    = 1'b0;

      if (cmd.accept) begin
         command_in = cmd_type'(req_command);
         port_in    = req_port;
         irq_in     = req_irq;
      end

      if (cmd.clear_wr) begin
         map_we = 1'b1;
         map_wa = clr_ff;
         map_wd = '0;
         clr_in = clr_ff + 1'b1;
      end

      if (cmd.exec) begin
         if (is_next) begin
            lw_in    = last_word_ff;
            lb_in    = last_bit_ff;
            found_in = 1'b0;
            if (work_ff == '0) begin
               work_in  = live_ff;
               live_in  = '0;
               flag_in  = 1'b0;
               phase_in = PH_WORD;
            end else begin
               phase_in = (last_bit_ff != TOP) ? PH_BIT : PH_POST;
            end
         end else if (in_range) begin
            arr_we = 1'b1;
            case (command_ff)
               CMD_RAISE: begin
                  if ((pend_w & pmask) == '0) begin
                     pend_wr = pend_w | pmask;
                     fire    = (mask_w & pmask) == '0;
                  end
               end
               CMD_MASK: begin
                  mask_wr = mask_w | pmask;
               end
               CMD_UNMASK: begin
                  mask_wr = mask_w & ~pmask;
                  fire    = (pend_w & pmask) != '0;
               end
               CMD_CLEAR: begin
                  pend_wr = pend_w & ~pmask;
               end
               CMD_BIND: begin
                  if (32'(irq_ff) < NUM_IRQS) begin
                     map_we = 1'b1;
                     map_wd = {1'b1, irq_ff};
                  end
               end
               CMD_UNBIND: begin
                  map_we = 1'b1;
                  map_wd = '0;
               end
               default: begin
                  arr_we = 1'b0;
               end
            endcase
            if (fire && pword < WORD_BITS && !live_ff[psel]) begin
               live_in[psel] = 1'b1;
               flag_in       = 1'b1;
            end
         end
      end

      if (cmd.scan_step) begin
         case (phase_ff)
            PH_WORD: begin
               if (work_ff == '0) begin
                  scan_done = 1'b1;
               end else begin
                  start = (lw_ff == TOP) ? '0 : lw_ff + 1'b1;
                  m1    = work_ff & (ones << start);
                  if (m1 == '0) begin
                     lw_in = TOP;
                     lb_in = TOP;
                  end else begin
                     lw_in    = lowest(m1);
                     phase_in = PH_BIT;
                  end
               end
            end
            PH_BIT: begin
               start = (lb_ff == TOP) ? '0 : lb_ff + 1'b1;
               m2    = act & (ones << start);
               if (m2 == '0) begin
                  lb_in    = TOP;
                  phase_in = PH_WORD;
                  if (act == '0) work_in[lw_ff] = 1'b0;
               end else begin
                  bsel           = lowest(m2);
                  scan_done      = 1'b1;
                  found_in       = 1'b1;
                  lb_in          = bsel;
                  last_word_in   = lw_ff;
                  last_bit_in    = bsel;
                  hit_in         = PW'(32'(lw_ff) * WORD_BITS + 32'(bsel));
                  arr_we         = word_ok;
                  mask_wr        = mask_w | (one << bsel);
                  pend_wr        = pend_w & ~(one << bsel);
               end
            end
            PH_POST: begin
               phase_in = PH_WORD;
               if (act == '0) work_in[lw_ff] = 1'b0;
            end
            default: begin
               phase_in = PH_WORD;
            end
         endcase
      end

      if (cmd.map_rd) begin
         if (is_next) begin
            map_ra    = MA_W'(32'(hit_ff));
            map_ok_in = found_ff && (32'(hit_ff) < NUM_PORTS);
         end else begin
            map_ra    = MA_W'(port_ext);
            map_ok_in = in_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      port_ff    <= port_in;
      irq_ff     <= irq_in;
      lw_ff      <= lw_in;
      lb_ff      <= lb_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      map_ok_ff  <= map_ok_in;
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            pend_ff[i] <= '0;
            mask_ff[i] <= '1;
         end
         live_ff      <= '0;
         work_ff      <= '0;
         flag_ff      <= 1'b0;
         last_word_ff <= TOP;
         last_bit_ff  <= TOP;
         phase_ff     <= PH_WORD;
         clr_ff       <= '0;
      end else begin
         if (arr_we) begin
            pend_ff[widx] <= pend_wr;
            mask_ff[widx] <= mask_wr;
         end
         live_ff      <= live_in;
         work_ff      <= work_in;
         flag_ff      <= flag_in;
         last_word_ff <= last_word_in;
         last_bit_ff  <= last_bit_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
      end
   end

   // Binding table: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (cmd.map_rd) map_q_ff <= map_mem[map_ra];
   end

   logic [MAP_W-1:0] entry;
   assign entry = map_ok_ff ? map_q_ff : '0;

   assign stat.clear_done = (clr_ff == MA_W'(NUM_PORTS - 1));
   assign stat.is_next    = is_next;
   assign stat.scan_done  = scan_done;

   assign result.found    = is_next && found_ff;
   assign result.out_port = is_next ? (found_ff ? PORT_W'(32'(hit_ff)) : '0) : port_ff;
   assign result.out_irq  = entry[IRQ_W-1:0];
   assign result.is_bound = entry[MAP_W-1];
   assign result.upcall   = flag_ff;

endmodule

>>> hdl/two_level_event_dispatcher.sv
// Event-port controller with pending and mask bitmaps and a two-level dispatch order.
// Requests arrive on the req_ channel (tvalid/tready/tdata) and each one produces
// exactly one response on the rsp_ channel. A request carries a command (raise,
// mask, unmask, clear, bind, unbind or next), a port number and an irq number.
// Only one request is in flight at a time: req_tready is high only while the
// block is idle, and it drops in the cycle after a request is taken.
// Commands other than next pass after acceptance through the exec state, which
// updates the bitmaps, the map state, which reads the binding table, and the
// result state, which loads the output register that drives rsp_tvalid. The
// block returns to idle only after that load. A next request also runs the
// dispatch scan in the scan state between exec and map; each step visits one selector word or one word
// of the active bitmap, so a scan takes from one up to about 2*WORD_BITS+2 steps.
// After reset the binding table, a memory of NUM_PORTS entries, is cleared one
// entry per cycle, so no request is accepted until every entry has been cleared.
// A response waits in the output register while rsp_tready is low, and the
// block holds the next request's result until that register is free.
module two_level_event_dispatcher #(
   parameter int WORD_BITS = 32,
   parameter int NUM_PORTS = 1024,
   parameter int NUM_IRQS  = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // command [2:0], port [12:3], irq_number [20:13], zero [23:21]
   input  logic [edp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // found [0], out_port [10:1], out_irq [18:11], upcall_flag_out [19], zero [23:20]
   output logic [edp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // is_bound [0]
   output logic                               rsp_tuser
);
   import edp_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   result_type   result;
   logic         out_free;

   // Output register: holds one response until the receiver takes it.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   edp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   edp_datapath #(
      .WORD_BITS (WORD_BITS),
      .NUM_PORTS (NUM_PORTS),
      .NUM_IRQS  (NUM_IRQS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_command (req_tdata[CMD_W-1:0]),
      .req_port    (req_tdata[CMD_W +: PORT_W]),
      .req_irq     (req_tdata[CMD_W+PORT_W +: IRQ_W]),
      .stat        (stat),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({result.upcall, result.out_irq,
                                      result.out_port, result.found});
         rsp_user_in  = result.is_bound;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A request is only taken while nothing else is in flight.
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another was in flight");

   // A new response appears exactly as the controller returns to idle.
   a_resp_on_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response loaded while the controller was not returning to idle");

endmodule

>>> tb/tb_two_level_event_dispatcher.sv
module tb_two_level_event_dispatcher;
   timeunit 1ns;
   timeprecision 1ps;
   import edp_pkg::*;

   localparam int WORDS = 32;
   localparam int NPORTS = 1024;
   localparam int NIRQS = 256;
   // The binding table is cleared one entry at a time after reset, and a
   // scan may take about 2*WORD_BITS+2 steps, so the watchdog allows a wide
   // margin over both.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [2:0] cmd;
      logic [9:0] port;
      logic [7:0] irq;
   } request_type;

   typedef struct packed {
      logic       found;
      logic [9:0] port;
      logic [7:0] irq;
      logic       bound;
      logic       upcall;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   two_level_event_dispatcher i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Shadow copy of the dispatcher state.
   logic [31:0] pend_map [WORDS];
   logic [31:0] mask_map [WORDS];
   logic [31:0] live_sel;
   logic [31:0] work_sel;
   logic        upcall;
   int unsigned last_w;
   int unsigned last_b;
   logic [8:0]  irq_table [NPORTS];

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   // Request layout on tdata: command lowest, then port, then irq.
   function automatic logic [REQ_TDATA_W-1:0] pack_request(request_type r);
      return {3'b000, r.irq, r.port, r.cmd};
   endfunction

   function automatic request_type unpack_request(logic [REQ_TDATA_W-1:0] d);
      request_type r;
      r.cmd = d[2:0];
      r.port = d[12:3];
      r.irq = d[20:13];
      return r;
   endfunction

   function automatic logic [31:0] active_word(int unsigned w);
      return pend_map[w] & ~mask_map[w];
   endfunction

   function automatic int unsigned lowest_one(logic [31:0] x);
      for (int i = 0; i < 32; i++)
         if (x[i])
            return i;
      return 0;
   endfunction

   function automatic void fire_word(int unsigned w);
      if (!live_sel[w]) begin
         live_sel[w] = 1'b1;
         upcall = 1'b1;
      end
   endfunction

   // Rotating two-level search: words of the working selector first, then
   // bits of the chosen word's active set, resuming after the last dispatch.
   function automatic bit scan_next(output int unsigned hw, output int unsigned hb);
      int unsigned lw, lb, start;
      int phase;
      logic [31:0] m;
      lw = last_w;
      lb = last_b;
      hw = 0;
      hb = 0;
      if (work_sel == 0) begin
         work_sel = live_sel;
         live_sel = 0;
         upcall = 1'b0;
         phase = 0;
      end else begin
         phase = (lb != 31) ? 1 : 2;
      end
      for (int it = 0; it < 4 * 32 + 4; it++) begin
         if (phase == 0) begin
            if (work_sel == 0)
               return 0;
            start = (lw + 1) % 32;
            m = work_sel & (32'hFFFF_FFFF << start);
            if (m == 0) begin
               lw = 31;
               lb = 31;
               continue;
            end
            lw = lowest_one(m);
            phase = 1;
         end
         if (phase == 1) begin
            start = (lb + 1) % 32;
            m = active_word(lw) & (32'hFFFF_FFFF << start);
            if (m == 0) begin
               lb = 31;
               phase = 2;
            end else begin
               lb = lowest_one(m);
               last_w = lw;
               last_b = lb;
               hw = lw;
               hb = lb;
               return 1;
            end
         end
         if (active_word(lw) == 0)
            work_sel[lw] = 1'b0;
         phase = 0;
      end
      return 0;
   endfunction

   function automatic response_type predict_dispatch(request_type r);
      response_type res;
      int unsigned w, b, p;
      logic [8:0] entry;
      entry = '0;
      res = '0;
      res.port = r.port;
      if (r.cmd == CMD_NEXT) begin
         res.port = '0;
         if (scan_next(w, b)) begin
            p = w * 32 + b;
            mask_map[w][b] = 1'b1;
            pend_map[w][b] = 1'b0;
            res.found = 1'b1;
            res.port = p[9:0];
            entry = irq_table[p];
         end
      end else begin
         w = r.port / 32;
         b = r.port % 32;
         case (r.cmd)
            CMD_RAISE: begin
               if (!pend_map[w][b]) begin
                  pend_map[w][b] = 1'b1;
                  if (!mask_map[w][b])
                     fire_word(w);
               end
            end
            CMD_MASK: mask_map[w][b] = 1'b1;
            CMD_UNMASK: begin
               mask_map[w][b] = 1'b0;
               if (pend_map[w][b])
                  fire_word(w);
            end
            CMD_CLEAR: pend_map[w][b] = 1'b0;
            CMD_BIND: begin
               if (int'(r.irq) < NIRQS)
                  irq_table[r.port] = {1'b1, r.irq};
            end
            CMD_UNBIND: irq_table[r.port] = '0;
            default: ;
         endcase
         entry = irq_table[r.port];
      end
      res.irq = entry[8] ? entry[7:0] : 8'd0;
      res.bound = entry[8];
      res.upcall = upcall;
      return res;
   endfunction

   task automatic add_request(logic [2:0] cmd, int unsigned port, int unsigned irq);
      request_type r;
      r.cmd = cmd;
      r.port = port[9:0];
      r.irq = irq[7:0];
      pending_requests.push_back(r);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned p;
      for (int i = 0; i < WORDS; i++) begin
         pend_map[i] = '0;
         mask_map[i] = '1;
      end
      foreach (irq_table[i])
         irq_table[i] = '0;
      live_sel = '0;
      work_sel = '0;
      upcall = 1'b0;
      last_w = 31;
      last_b = 31;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extreme ports and irqs, every command, next on an empty
      // map, raise of a pending port, unmask of a pending port, and a command
      // code that the block does not define.
      add_request(CMD_NEXT, 0, 0);
      add_request(CMD_BIND, 1023, 255);
      add_request(CMD_BIND, 0, 0);
      add_request(CMD_RAISE, 1023, 0);
      add_request(CMD_RAISE, 1023, 0);
      add_request(CMD_UNMASK, 1023, 0);
      add_request(CMD_RAISE, 0, 0);
      add_request(CMD_UNMASK, 0, 0);
      add_request(CMD_RAISE, 31, 170);
      add_request(CMD_UNMASK, 31, 85);
      add_request(CMD_NEXT, 0, 0);
      add_request(CMD_NEXT, 1023, 255);
      add_request(CMD_NEXT, 0, 0);
      add_request(CMD_NEXT, 0, 0);
      add_request(CMD_MASK, 512, 0);
      add_request(CMD_CLEAR, 1023, 0);
      add_request(CMD_UNBIND, 1023, 0);
      add_request(3'd7, 1023, 255);
      add_request(3'd7, 0, 0);
      add_request(CMD_NEXT, 0, 0);

      // Wait for the directed part to drain before pressing on.
      while (pending_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      hold_sender = 1'b1;
      while (expected_responses.size() != 0)
         @(posedge clock);
      hold_sender = 1'b0;

      // Random part: ports cluster in a few words so that dispatch finds
      // work; occasional ports land anywhere.
      for (int n = 0; n < 500; n++) begin
         int unsigned c;
         c = $urandom_range(0, 99);
         if ($urandom_range(0, 4) == 0)
            p = $urandom_range(0, 1023);
         else
            p = 32 * ($urandom_range(0, 3) * 10 + $urandom_range(0, 1)) +
                $urandom_range(0, 31);
         if (c < 25)
            add_request(CMD_RAISE, p, $urandom);
         else if (c < 40)
            add_request(CMD_UNMASK, p, $urandom);
         else if (c < 47)
            add_request(CMD_MASK, p, $urandom);
         else if (c < 52)
            add_request(CMD_CLEAR, p, $urandom);
         else if (c < 60)
            add_request(CMD_BIND, p, $urandom);
         else if (c < 63)
            add_request(CMD_UNBIND, p, $urandom);
         else if (c < 65)
            add_request(3'd7, p, $urandom);
         else
            add_request(CMD_NEXT, $urandom, $urandom);
      end
      while (pending_requests.size() != 0)
         @(posedge clock);
      stim_done = 1'b1;
   end

   // Handshake history, seen by the falling-edge blocks.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   // Driver: one request at a time, with a random gap before each.
   int send_gap = 0;
   always @(negedge clock) begin
      if (req_taken) begin
         // The request was taken at the last rising edge.
         req_tvalid <= 1'b0;
         send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end else if (!req_tvalid && !reset && !hold_sender && pending_requests.size() > 0) begin
         if (send_gap > 0) begin
            send_gap--;
         end else begin
            req_tdata <= pack_request(pending_requests.pop_front());
            req_tvalid <= 1'b1;
         end
      end
   end

   // Predict at the accepting edge so that expectations stay in order.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_responses.push_back(predict_dispatch(unpack_request(req_tdata)));
   end

   // Receiver: a random stall before each response is taken.
   int stall = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         rsp_tready <= (stall == 0);
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= (stall == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each response field by field with the oldest
   // expectation.
   always @(posedge clock) begin
      response_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found = rsp_tdata[0];
         got.port = rsp_tdata[10:1];
         got.irq = rsp_tdata[18:11];
         got.upcall = rsp_tdata[19];
         got.bound = rsp_tuser;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: found %0d port %0d irq %0d bound %0d upcall %0d",
                        got.found, got.port, got.irq, got.bound, got.upcall);
         end else begin
            want = expected_responses.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected found %0d port %0d irq %0d bound %0d ",
                            "upcall %0d, got found %0d port %0d irq %0d bound %0d upcall %0d"},
                           want.found, want.port, want.irq, want.bound, want.upcall,
                           got.found, got.port, got.irq, got.bound, got.upcall);
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
